// File: rtl/core/tses_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tses_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_TERMS = 32;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int SAT_W     = PROD_W + 2;
  localparam int DIV_W     = 16;
  localparam int CNT_W     = 7;
  localparam int TOL_W     = 25;
  localparam int X_W       = 28;
  localparam int STEP_W    = $clog2(WORD_W);

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t FX_ONE   = word_t'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_EXP  = 2'd0,
    MODE_SIN  = 2'd1,
    MODE_COS  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XSQ,
    S_CHECK,
    S_CALC,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL,
    M_SCALE,
    M_PREP,
    M_DIV,
    M_DONE
  } md_state_t;

  typedef struct packed {
    word_t            a;
    word_t            b;
    logic [DIV_W-1:0] divisor;
    logic             negate;
  } md_req_t;

  function automatic word_t sat_word(input logic signed [SAT_W-1:0] v);
    word_t r;
    if (v > $signed({{(SAT_W-WORD_W){1'b0}}, WORD_MAX})) begin
      r = WORD_MAX;
    end else if (v < $signed({{(SAT_W-WORD_W){1'b1}}, WORD_MIN})) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] mag_word(input word_t v);
    logic [WORD_W-1:0] r;
    r = v[WORD_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  function automatic logic signed [SAT_W-1:0] ext_word(input word_t v);
    logic signed [SAT_W-1:0] r;
    r = {{(SAT_W-WORD_W){v[WORD_W-1]}}, v};
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/tses_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
module tses_muldiv (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  tses_pkg::md_req_t   req,
  output logic                done,
  output tses_pkg::word_t     res
);
  import tses_pkg::*;

  md_state_t               st_r, st_nxt;
  logic [PROD_W-1:0]       mcand_r, mcand_nxt;
  logic [PROD_W-1:0]       acc_r, acc_nxt;
  logic [WORD_W-1:0]       mplier_r, mplier_nxt;
  logic [WORD_W-1:0]       quo_r, quo_nxt;
  logic [DIV_W-1:0]        rem_r, rem_nxt;
  logic [DIV_W-1:0]        div_r, div_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    psign_r, psign_nxt;
  logic                    qsign_r, qsign_nxt;
  logic                    negate_r, negate_nxt;
  word_t                   prod_r, prod_nxt;
  word_t                   res_r, res_nxt;
  logic                    done_r, done_nxt;

  logic signed [PROD_W:0]   sprod;
  logic signed [PROD_W:0]   sshift;
  logic [DIV_W+1:0]         diff;
  logic signed [WORD_W:0]   qsigned;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
    mplier_r <= mplier_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    step_r   <= step_nxt;
    psign_r  <= psign_nxt;
    qsign_r  <= qsign_nxt;
    negate_r <= negate_nxt;
    prod_r   <= prod_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    st_nxt     = st_r;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    mplier_nxt = mplier_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    step_nxt   = step_r;
    psign_nxt  = psign_r;
    qsign_nxt  = qsign_r;
    negate_nxt = negate_r;
    prod_nxt   = prod_r;
    res_nxt    = res_r;
    done_nxt   = 1'b0;
    sprod      = psign_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
    sshift     = sprod >>> FRAC_BITS;
    diff       = {1'b0, rem_r, quo_r[WORD_W-1]} - {2'b00, div_r};
    qsigned    = qsign_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    case (st_r)
      M_IDLE: begin
        if (start) begin
          mcand_nxt  = {{(PROD_W-WORD_W){1'b0}}, mag_word(req.a)};
          mplier_nxt = mag_word(req.b);
          acc_nxt    = '0;
          psign_nxt  = req.a[WORD_W-1] ^ req.b[WORD_W-1];
          negate_nxt = req.negate;
          div_nxt    = req.divisor;
          step_nxt   = '0;
          st_nxt     = M_MUL;
        end
      end
      // shift-add, one multiplier bit per cycle
      M_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[WORD_W-1:1]};
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_W'(WORD_W-1)) begin
          st_nxt = M_SCALE;
        end
      end
      M_SCALE: begin
        prod_nxt = sat_word({sshift[PROD_W], sshift});
        st_nxt   = M_PREP;
      end
      M_PREP: begin
        quo_nxt   = mag_word(prod_r);
        rem_nxt   = '0;
        qsign_nxt = prod_r[WORD_W-1] ^ negate_r;
        step_nxt  = '0;
        st_nxt    = M_DIV;
      end
      // restoring division, one quotient bit per cycle
      M_DIV: begin
        if (!diff[DIV_W+1]) begin
          rem_nxt = diff[DIV_W-1:0];
          quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DIV_W-2:0], quo_r[WORD_W-1]};
          quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(WORD_W-1)) begin
          st_nxt = M_DONE;
        end
      end
      M_DONE: begin
        res_nxt  = sat_word({{(SAT_W-WORD_W-1){qsigned[WORD_W]}}, qsigned});
        done_nxt = 1'b1;
        st_nxt   = M_IDLE;
      end
      default: begin
        st_nxt = M_IDLE;
      end
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

`ifndef NO_ASSERTIONS
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && st_r == M_IDLE) |=> st_r == M_MUL)
    else $error("muldiv did not start");
  a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(st_r) == M_DONE)
    else $error("done without finishing division");
  a_no_divide_by_zero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == M_DIV |-> div_r != '0)
    else $error("zero divisor");
`endif

endmodule
`default_nettype wire

// File: rtl/core/taylor_series_exp_sin_cos.sv
// channel  dir  tdata                                        tuser
// in_      in   x_value[27:0] tolerance[52:28] pad[55:53]    mode[1:0]
// out_     out  result[31:0] terms_used[37:32]               -
//               not_converged[38] pad[39]
// each term costs one serial multiply and one serial divide
// unused mode skips the series and gives a zero result; one item is worked at a time
// reset is synchronous, active low, and clears control only
// a new word is taken while the previous result waits on out_tready
`timescale 1ns / 1ps
`default_nettype none
module taylor_series_exp_sin_cos (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [55:0] in_tdata,   // x_value, tolerance
  input  wire  [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata   // result, terms_used, not_converged
);
  import tses_pkg::*;

  state_t            st_r, st_nxt;
  mode_t             mode_r, mode_nxt;
  word_t             x_r, x_nxt;
  logic [TOL_W-1:0]  tol_r, tol_nxt;
  word_t             xsq_r, xsq_nxt;
  word_t             term_r, term_nxt;
  word_t             sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              nc_r, nc_nxt;
  logic              start_r, start_nxt;
  md_req_t           req_r, req_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [39:0]       out_data_r, out_data_nxt;

  logic              md_done;
  word_t             md_res;
  logic              above;
  logic [2*CNT_W-1:0] pair;
  word_t             x_in;

  tses_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .req   (req_r),
    .done  (md_done),
    .res   (md_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    x_r        <= x_nxt;
    tol_r      <= tol_nxt;
    xsq_r      <= xsq_nxt;
    term_r     <= term_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    nc_r       <= nc_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    mode_nxt      = mode_r;
    x_nxt         = x_r;
    tol_nxt       = tol_r;
    xsq_nxt       = xsq_r;
    term_nxt      = term_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    nc_nxt        = nc_r;
    start_nxt     = 1'b0;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = (st_r == S_IDLE);
    x_in          = {{(WORD_W-X_W){in_tdata[X_W-1]}}, in_tdata[X_W-1:0]};
    above         = mag_word(term_r) > {{(WORD_W-TOL_W){1'b0}}, tol_r};
    pair          = idx_r * (idx_r - 1'b1);
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = mode_t'(in_tuser);
          x_nxt    = x_in;
          tol_nxt  = in_tdata[X_W+TOL_W-1:X_W];
          case (mode_t'(in_tuser))
            MODE_EXP: begin
              term_nxt = FX_ONE;
              sum_nxt  = '0;
              cnt_nxt  = '0;
              idx_nxt  = CNT_W'(1);
              st_nxt   = S_CHECK;
            end
            MODE_SIN, MODE_COS: begin
              req_nxt.a       = x_in;
              req_nxt.b       = x_in;
              req_nxt.divisor = DIV_W'(1);
              req_nxt.negate  = 1'b0;
              start_nxt       = 1'b1;
              st_nxt          = S_XSQ;
            end
            default: begin
              sum_nxt = '0;
              cnt_nxt = '0;
              nc_nxt  = 1'b0;
              st_nxt  = S_OUT;
            end
          endcase
        end
      end
      S_XSQ: begin
        if (md_done) begin
          xsq_nxt  = md_res;
          term_nxt = (mode_r == MODE_SIN) ? x_r : FX_ONE;
          sum_nxt  = (mode_r == MODE_SIN) ? x_r : FX_ONE;
          cnt_nxt  = CNT_W'(1);
          idx_nxt  = (mode_r == MODE_SIN) ? CNT_W'(3) : CNT_W'(2);
          st_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (above && cnt_r < CNT_W'(MAX_TERMS)) begin
          start_nxt = 1'b1;
          req_nxt.a = term_r;
          if (mode_r == MODE_EXP) begin
            sum_nxt         = sat_word(ext_word(sum_r) + ext_word(term_r));
            cnt_nxt         = cnt_r + 1'b1;
            req_nxt.b       = x_r;
            req_nxt.divisor = {{(DIV_W-CNT_W){1'b0}}, idx_r};
            req_nxt.negate  = 1'b0;
          end else begin
            req_nxt.b       = xsq_r;
            req_nxt.divisor = {{(DIV_W-2*CNT_W){1'b0}}, pair};
            req_nxt.negate  = 1'b1;
          end
          st_nxt = S_CALC;
        end else begin
          nc_nxt = above;
          st_nxt = S_OUT;
        end
      end
      S_CALC: begin
        if (md_done) begin
          term_nxt = md_res;
          if (mode_r == MODE_EXP) begin
            idx_nxt = idx_r + 1'b1;
          end else begin
            sum_nxt = sat_word(ext_word(sum_r) + ext_word(md_res));
            cnt_nxt = cnt_r + 1'b1;
            idx_nxt = idx_r + CNT_W'(2);
          end
          st_nxt = S_CHECK;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, nc_r, cnt_r[5:0], sum_r};
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> st_r != S_IDLE)
    else $error("accepted word did not start work");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CHECK |-> cnt_r <= CNT_W'(MAX_TERMS))
    else $error("term count beyond limit");
  a_nc_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[38]) |-> out_data_r[37:32] == 6'(MAX_TERMS))
    else $error("not converged below term limit");
`endif

endmodule
`default_nettype wire

// File: bench/taylor_series_exp_sin_cos_test.sv
`timescale 1ns / 1ps
module taylor_series_exp_sin_cos_test;
  import tses_pkg::*;

  localparam int WATCHDOG = 200000;
  localparam int N_RANDOM = 500;
  localparam longint ONE_Q = 64'sd1 << FRAC_BITS;

  typedef struct packed {
    logic [31:0] result;
    logic [5:0]  terms;
    logic        nc;
  } series_out_t;

  typedef struct {
    mode_t       mode;
    logic [27:0] x;
    logic [24:0] tol;
    logic        known;
    series_out_t want;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  series_out_t sums_pending[$];
  int          errors = 0;
  int          quiet = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  always #6 clk = ~clk;

  taylor_series_exp_sin_cos u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> FRAC_BITS);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic series_out_t series_eval(mode_t mode, logic [27:0] xr, logic [24:0] tr);
    longint x, tol, term, acc, i, xsq;
    int cnt;
    series_out_t r;
    x = longint'($signed(xr));
    tol = longint'(tr);
    if (mode == MODE_NONE) return '0;
    if (mode == MODE_EXP) begin
      term = ONE_Q; acc = 0; cnt = 0; i = 1;
      while (absl(term) > tol && cnt < MAX_TERMS) begin
        acc = clamp32(acc + term);
        cnt++;
        term = clamp32(qmul(term, x) / i);
        i++;
      end
    end else begin
      xsq = qmul(x, x);
      if (mode == MODE_SIN) begin
        term = x; i = 3;
      end else begin
        term = ONE_Q; i = 2;
      end
      acc = term; cnt = 1;
      while (absl(term) > tol && cnt < MAX_TERMS) begin
        term = clamp32(-(qmul(term, xsq) / (i * (i - 1))));
        acc = clamp32(acc + term);
        cnt++;
        i += 2;
      end
    end
    r.result = acc[31:0];
    r.terms = cnt[5:0];
    r.nc = absl(term) > tol;
    return r;
  endfunction

  vector_t directed[$];

  function automatic vector_t row(mode_t m, logic [27:0] x, logic [24:0] t,
                                  logic k = 1'b0, series_out_t w = '0);
    vector_t v;
    v.mode = m; v.x = x; v.tol = t; v.known = k; v.want = w;
    return v;
  endfunction

  task automatic send(mode_t m, logic [27:0] x, logic [24:0] t, logic k, series_out_t w);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= m;
    in_tdata <= {3'b0, t, x};
    sums_pending.push_back(k ? w : series_eval(m, x, t));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    series_out_t got, exp_o;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[37:32], out_tdata[38]};
        if (sums_pending.size() == 0) begin
          $error("unexpected word %h", out_tdata);
          errors++;
        end else begin
          exp_o = sums_pending.pop_front();
          if (got.result !== exp_o.result) begin
            $error("result exp %h got %h", exp_o.result, got.result); errors++;
          end
          if (got.terms !== exp_o.terms) begin
            $error("terms_used exp %0d got %0d", exp_o.terms, got.terms); errors++;
          end
          if (got.nc !== exp_o.nc) begin
            $error("not_converged exp %0d got %0d", exp_o.nc, got.nc); errors++;
          end
        end
      end
      out_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WATCHDOG) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [27:0] rand_x();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 28'(32'h0400_0000);
    if (r == 1) return 28'(-32'sh0400_0000);
    if (r == 2) return 28'($urandom);
    return 28'($signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  function automatic logic [24:0] rand_tol();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return 25'($urandom);
    if (r < 5) return 25'($urandom_range(255));
    return 25'($urandom_range(32'h0100_0000) >> $urandom_range(24));
  endfunction

  initial begin
    int ph;
    directed.push_back(row(MODE_NONE, 28'h0, 25'h0, 1'b1, '0));
    directed.push_back(row(MODE_NONE, 28'hfff_ffff, 25'h1ff_ffff, 1'b1, '0));
    directed.push_back(row(MODE_EXP, 28'h0, 25'h100_0000, 1'b1, '0));
    directed.push_back(row(MODE_EXP, 28'h123_4567, 25'h1ff_ffff, 1'b1, '0));
    directed.push_back(row(MODE_SIN, 28'h0, 25'h0, 1'b1, '{32'h0, 6'd1, 1'b0}));
    directed.push_back(row(MODE_COS, 28'h0, 25'h100_0000, 1'b1,
                           '{32'h0100_0000, 6'd1, 1'b0}));
    directed.push_back(row(MODE_EXP, 28'h0, 25'h0));
    directed.push_back(row(MODE_EXP, 28'h400_0000, 25'h0));
    directed.push_back(row(MODE_EXP, 28'hc00_0000, 25'h0));
    directed.push_back(row(MODE_EXP, 28'h100_0000, 25'h1));
    directed.push_back(row(MODE_SIN, 28'h400_0000, 25'h0));
    directed.push_back(row(MODE_SIN, 28'hc00_0000, 25'h0));
    directed.push_back(row(MODE_SIN, 28'h080_0000, 25'h100));
    directed.push_back(row(MODE_COS, 28'h400_0000, 25'h0));
    directed.push_back(row(MODE_COS, 28'hc00_0000, 25'h1));
    directed.push_back(row(MODE_COS, 28'h100_0000, 25'h100_0000));
    directed.push_back(row(MODE_EXP, 28'h7ff_ffff, 25'h0));
    directed.push_back(row(MODE_SIN, 28'h800_0000, 25'h0));
    directed.push_back(row(MODE_COS, 28'h7ff_ffff, 25'h0));
    directed.push_back(row(MODE_EXP, 28'h800_0000, 25'h0));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[k])
      send(directed[k].mode, directed[k].x, directed[k].tol,
           directed[k].known, directed[k].want);
    for (int n = 0; n < N_RANDOM; n++) begin
      ph = (n / 50) % 4;
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 11) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 59 : 11) : 0;
      if (n == 250) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sums_pending.size() != 0) @(posedge clk);
      end
      send(mode_t'($urandom_range(15) == 0 ? 3 : $urandom_range(2)),
           rand_x(), rand_tol(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    while (sums_pending.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (errors == 0 && sums_pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
